@@ rtl/adpcm_pkg.sv @@
// shared types, tables and helpers for the 8-bit sample adpcm codec
package adpcm_pkg;

  localparam int unsigned StepLast = 48;
  localparam int unsigned StepW    = 9;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned DeltaW   = 10;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [StepW-1:0] STEP_TABLE [StepLast+1] = '{
    9'd1,   9'd1,   9'd1,   9'd1,   9'd2,   9'd2,   9'd2,   9'd3,   9'd3,   9'd4,
    9'd4,   9'd5,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,  9'd11,  9'd13,
    9'd14,  9'd16,  9'd18,  9'd20,  9'd22,  9'd25,  9'd28,  9'd31,  9'd35,  9'd39,
    9'd44,  9'd49,  9'd55,  9'd61,  9'd68,  9'd76,  9'd85,  9'd95,  9'd106, 9'd118,
    9'd132, 9'd147, 9'd164, 9'd183, 9'd204, 9'd228, 9'd254, 9'd283, 9'd315
  };

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [3:0] code;
    logic [7:0] sample;
    logic       raw;
  } result_t;

  typedef struct packed {
    logic [7:0]      predictor;
    logic [IdxW-1:0] step_index;
  } codec_state_t;

  function automatic logic [StepW-1:0] step_size(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] i;
    i = (idx > IdxW'(StepLast)) ? IdxW'(StepLast) : idx;
    return STEP_TABLE[i];
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    unique case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

@@ rtl/adpcm_if.sv @@
// stream and configuration channel interfaces of the adpcm codec
interface adpcm_in_if;
  logic                 valid;
  logic                 ready;
  adpcm_pkg::item_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface adpcm_out_if;
  logic                 valid;
  logic                 ready;
  adpcm_pkg::result_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface adpcm_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

@@ rtl/adpcm_step.sv @@
// one codec step: quantize or rebuild the difference, update predictor and step index
module adpcm_step (
  input  logic                    mode_i,
  input  adpcm_pkg::item_t        item_i,
  input  adpcm_pkg::codec_state_t state_i,
  output adpcm_pkg::result_t      result_o,
  output adpcm_pkg::codec_state_t state_o
);
  import adpcm_pkg::*;

  logic [StepW-1:0]  step;
  logic [StepW-1:0]  stp;
  logic [8:0]        mag;
  logic [3:0]        enc_code;
  logic [3:0]        code;
  logic [DeltaW-1:0] delta_e;
  logic [DeltaW-1:0] delta_d;
  logic [DeltaW-1:0] delta;
  logic signed [11:0] p_next;
  logic signed [7:0]  k_next;
  logic [7:0]         pred_clamped;
  logic [IdxW-1:0]    idx_clamped;

  assign step = step_size(state_i.step_index);

  // successive approximation over three magnitude bits
  always_comb begin
    enc_code    = '0;
    enc_code[3] = (item_i.data_in < state_i.predictor);
    mag = enc_code[3] ? (9'(state_i.predictor) - 9'(item_i.data_in))
                      : (9'(item_i.data_in) - 9'(state_i.predictor));
    stp     = step;
    delta_e = DeltaW'(step >> 3);
    for (int b = 2; b >= 0; b--) begin
      if (mag >= stp) begin
        enc_code[b] = 1'b1;
        mag         = mag - stp;
        delta_e     = delta_e + DeltaW'(stp);
      end
      stp = stp >> 1;
    end
  end

  always_comb begin
    delta_d = DeltaW'(step >> 3);
    if (item_i.data_in[2]) delta_d = delta_d + DeltaW'(step);
    if (item_i.data_in[1]) delta_d = delta_d + DeltaW'(step >> 1);
    if (item_i.data_in[0]) delta_d = delta_d + DeltaW'(step >> 2);
  end

  assign code  = (mode_i == MODE_DECODE) ? item_i.data_in[3:0] : enc_code;
  assign delta = (mode_i == MODE_DECODE) ? delta_d : delta_e;

  always_comb begin
    if (code[3]) p_next = $signed({4'b0, state_i.predictor}) - $signed({2'b0, delta});
    else         p_next = $signed({4'b0, state_i.predictor}) + $signed({2'b0, delta});
    if (p_next < 12'sd0)        pred_clamped = 8'd0;
    else if (p_next > 12'sd255) pred_clamped = 8'd255;
    else                        pred_clamped = p_next[7:0];

    k_next = $signed({2'b0, state_i.step_index}) + 8'(index_adjust(code[2:0]));
    if (k_next < 8'sd0)                      idx_clamped = '0;
    else if (k_next > 8'sd48)                idx_clamped = IdxW'(StepLast);
    else                                     idx_clamped = k_next[IdxW-1:0];
  end

  always_comb begin
    if (item_i.start_req) begin
      result_o.code         = 4'd0;
      result_o.sample       = item_i.data_in;
      result_o.raw          = 1'b1;
      state_o.predictor     = item_i.data_in;
      state_o.step_index    = '0;
    end else begin
      result_o.code         = code;
      result_o.sample       = pred_clamped;
      result_o.raw          = 1'b0;
      state_o.predictor     = pred_clamped;
      state_o.step_index    = idx_clamped;
    end
  end

endmodule

@@ rtl/adpcm_8bit_sample_codec.sv @@
// top level of the 4-bit adpcm codec for 8-bit unsigned samples
//
// channels: din_i takes items (start_req, data_in); dout_o gives results
// (code, sample, raw), one result per item; cfg_i writes the mode register
// (0 encode, 1 decode) and is always ready. write mode only while idle.
// an item with start_req set loads the predictor with data_in, clears the
// step index and comes out unchanged with raw set and code zero.
// path: an item in the input register is processed by the step logic and
// lands in the output register once that is free or being read, visible
// from then on. throughput: one item per cycle while dout_o is not stalled,
// set by the single predictor/step index update between the two registers.
// reset clears mode, predictor, step index and both valid flags.
// when the receiver stalls, the output register holds its result and the
// input register still takes one more item, then din_i.ready drops until
// the output is transferred.
module adpcm_8bit_sample_codec (
  input  logic  clk_i,
  input  logic  rst_ni,
  adpcm_in_if.sink    din_i,
  adpcm_out_if.source dout_o,
  adpcm_cfg_if.sink   cfg_i
);
  import adpcm_pkg::*;

  logic         mode_q;
  logic         in_valid_q;
  item_t        in_q;
  logic         out_valid_q;
  result_t      out_q;
  codec_state_t state_q;
  codec_state_t state_d;
  result_t      result_d;
  logic         advance;

  assign advance     = in_valid_q && (!out_valid_q || dout_o.ready);
  assign din_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign dout_o.valid   = out_valid_q;
  assign dout_o.payload = out_q;

  adpcm_step u_step (
    .mode_i   (mode_q),
    .item_i   (in_q),
    .state_i  (state_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCODE;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (cfg_i.valid) mode_q <= cfg_i.mode;
      if (din_i.ready) in_valid_q <= din_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (dout_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (din_i.valid && din_i.ready) in_q <= din_i.payload;
    if (advance) out_q <= result_d;
  end

  a_raw_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.raw |-> out_q.code == 4'd0)
    else $error("raw result with nonzero code");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step_index <= IdxW'(StepLast))
    else $error("step index out of range");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled item lost from input register");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.start_req |=>
      state_q.step_index == '0 && state_q.predictor == $past(in_q.data_in))
    else $error("start did not load the predictor");

endmodule
